### rtl/core/ppr_pkg.sv
package ppr_pkg;

    localparam int DATA_W           = 16;
    localparam int DUTY_W           = 8;
    localparam int OUT_W            = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int SAMPLE_BITS_DEF  = 10;
    localparam int OUTPUT_SHIFT_DEF = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 2'd0,
        REG_GAIN_P   = 2'd1,
        REG_GAIN_I   = 2'd2,
        REG_GAIN_D   = 2'd3
    } cfg_reg_t;

    // Truncated products handed from the multiplier stage to the accumulate stage.
    typedef struct packed {
        logic [DATA_W-1:0] p;
        logic [DATA_W-1:0] i;
        logic [DATA_W-1:0] d;
        logic              changed;
    } terms_t;

endpackage

### rtl/core/ppr_term_mult.sv
module ppr_term_mult
    import ppr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] err,
    input  logic [DATA_W-1:0] delta,
    input  logic              changed,
    input  logic [DATA_W-1:0] gain_p,
    input  logic [DATA_W-1:0] gain_i,
    input  logic [DATA_W-1:0] gain_d,
    output terms_t            terms
);

    terms_t terms_reg;
    terms_t terms_next;

    // Only the low half of each product is ever used, so each multiplier is 16x16 low.
    always_comb
    begin
        terms_next.p       = DATA_W'(err * gain_p);
        terms_next.i       = DATA_W'(err * gain_i);
        terms_next.d       = DATA_W'(delta * gain_d);
        terms_next.changed = changed;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

### rtl/core/pid_pwm_regulator.sv
// A sample accepted at the input passes the stage 1, product and output registers in turn.
// Throughput: one sample per cycle while m_tready is high; the three gain products sit in
// their own stage, and the integral and duty loops close inside the single accumulate stage.
// Reset (rst_n, asynchronous, active low) clears the gains, setpoint, offset,
// previous error, integral, held duty and overflow, and empties the pipeline.
module pid_pwm_regulator
    import ppr_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int OUTPUT_SHIFT = OUTPUT_SHIFT_DEF,
    localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // adc_sample

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata    // pwm_duty[7:0], overflow, updated
);

    logic [DATA_W-1:0]      setpoint_reg;
    logic [DATA_W-1:0]      gain_p_reg;
    logic [DATA_W-1:0]      gain_i_reg;
    logic [DATA_W-1:0]      gain_d_reg;

    logic                   calibrated_reg;
    logic [SAMPLE_BITS-1:0] offset_reg;
    logic [DATA_W-1:0]      prev_error_reg;

    logic                   s1_valid_reg;
    logic [DATA_W-1:0]      s1_err_reg;
    logic [DATA_W-1:0]      s1_delta_reg;
    logic                   s1_changed_reg;

    logic                   s2_valid_reg;
    terms_t                 terms;

    logic                   out_valid_reg;
    logic                   out_upd_reg;
    logic [DATA_W-1:0]      integral_reg;
    logic [DUTY_W-1:0]      duty_hold_reg;
    logic                   ovf_hold_reg;

    logic                   s3_en;
    logic                   s2_take;
    logic                   s1_take;
    logic                   in_fire;
    logic                   s2_fire;

    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] offset_sel;
    logic [DATA_W-1:0]      err_next;

    logic [DATA_W-1:0]      ti_raw;
    logic                   ti_keep;
    logic [DATA_W-1:0]      ti;
    logic [DATA_W-1:0]      sum;
    logic [DATA_W-1:0]      sum_clamped;
    logic [DATA_W-1:0]      integral_next;
    logic [DUTY_W-1:0]      duty_hold_next;
    logic                   ovf_hold_next;

    // Each stage moves forward when the one after it is empty or moving too.
    assign s3_en    = !out_valid_reg || m_tready;
    assign s2_take  = !s2_valid_reg || s3_en;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign s_tready = s1_take;
    assign in_fire  = s_tvalid && s_tready;
    assign s2_fire  = s2_valid_reg && s3_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SETPOINT: setpoint_reg <= cfg_wdata;
                REG_GAIN_P:   gain_p_reg   <= cfg_wdata;
                REG_GAIN_I:   gain_i_reg   <= cfg_wdata;
                REG_GAIN_D:   gain_d_reg   <= cfg_wdata;
            endcase
        end
    end

    // Stage 1: offset correction and error, taken straight from the input transaction.
    always_comb
    begin
        sample     = s_tdata[SAMPLE_BITS-1:0];
        offset_sel = calibrated_reg ? offset_reg : sample;
        err_next   = setpoint_reg - (DATA_W'(offset_sel) - DATA_W'(sample));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrated_reg <= 1'b0;
            offset_reg     <= '0;
            prev_error_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= in_fire;
            end
            if (in_fire)
            begin
                calibrated_reg <= 1'b1;
                offset_reg     <= offset_sel;
                prev_error_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_err_reg     <= err_next;
            s1_delta_reg   <= err_next - prev_error_reg;
            s1_changed_reg <= err_next != prev_error_reg;
        end
    end

    // Stage 2: the three gain products.
    ppr_term_mult u_term_mult (
        .clk     (clk),
        .en      (s2_take),
        .err     (s1_err_reg),
        .delta   (s1_delta_reg),
        .changed (s1_changed_reg),
        .gain_p  (gain_p_reg),
        .gain_i  (gain_i_reg),
        .gain_d  (gain_d_reg),
        .terms   (terms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 3: integral update, sum, clamp and duty. The held values double as
    // the output payload, so an unchanged error simply repeats them.
    always_comb
    begin
        ti_raw      = terms.i + integral_reg;
        ti_keep     = (ti_raw != '0) && !ti_raw[DATA_W-1];
        ti          = ti_keep ? ti_raw : integral_reg;
        sum         = terms.p + ti + terms.d;
        sum_clamped = sum[DATA_W-1] ? '0 : sum;

        integral_next  = integral_reg;
        duty_hold_next = duty_hold_reg;
        ovf_hold_next  = ovf_hold_reg;
        if (s2_fire && terms.changed)
        begin
            integral_next  = ti;
            duty_hold_next = DUTY_W'(sum_clamped >> OUTPUT_SHIFT);
            ovf_hold_next  = sum[DATA_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_upd_reg   <= 1'b0;
            integral_reg  <= '0;
            duty_hold_reg <= '0;
            ovf_hold_reg  <= 1'b0;
        end
        else
        begin
            if (s3_en)
            begin
                out_valid_reg <= s2_valid_reg;
                out_upd_reg   <= terms.changed;
            end
            integral_reg  <= integral_next;
            duty_hold_reg <= duty_hold_next;
            ovf_hold_reg  <= ovf_hold_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - DUTY_W - 2){1'b0}}, out_upd_reg, ovf_hold_reg, duty_hold_reg};

`ifndef ASSERT_OFF
    a_integral_positive: assert property (@(posedge clk) disable iff (!rst_n)
        !integral_reg[DATA_W-1])
        else $error("integral went negative");

    a_overflow_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_hold_reg |-> duty_hold_reg == '0)
        else $error("clamped sum left a nonzero duty");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg && s2_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_calibrated_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        calibrated_reg |=> calibrated_reg)
        else $error("offset calibration lost");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(duty_hold_reg) && $stable(integral_reg))
        else $error("held state changed while the result was waiting");
`endif

endmodule
